// ===== rtl/gc3_pkg.sv =====
// gc3_pkg: shared types, register codes, reset values and helpers for the
// 3x3 directional gradient block. No dependencies.
`timescale 1ns / 1ps

package gc3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W      = 8;
    localparam int WEIGHT_W   = 8;
    localparam int DIM_W      = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_WEIGHT_A = 3'd1,
        CFG_WEIGHT_C = 3'd2,
        CFG_WEIGHT_B = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } t_cfg_idx;

    localparam logic OP_DRAIN = 1'b1;
    localparam logic MODE_X   = 1'b1;

    localparam logic                       RST_MODE     = 1'b1;
    localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_A = 8'sd1;
    localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_C = 8'sd2;
    localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT_B = 8'sd1;
    localparam logic [DIM_W-1:0]           RST_WIDTH    = 11'd640;
    localparam logic [DIM_W-1:0]           RST_HEIGHT   = 11'd480;

    // result queue: one slot per word in flight behind the input
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    // one window column: previous, current and next row
    typedef struct packed {
        logic [PIX_W-1:0] prev;
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] next;
    } t_wcol;

    // control carried with a pushed pixel into the kernel stage
    typedef struct packed {
        logic valid;
        logic byp;
        logic res;
        logic left;
        logic right;
        logic top;
        logic bottom;
        logic last;
    } t_s1_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] gradient;
        logic             frame_end;
    } t_result;

    // low byte of a product; signedness does not affect these bits
    function automatic logic [PIX_W-1:0] mul_lo8(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        logic [2*PIX_W-1:0] p;
        p = (2*PIX_W)'(a) * (2*PIX_W)'(b);
        return p[PIX_W-1:0];
    endfunction

endpackage

// ===== rtl/gc3_line_store.sv =====
// gc3_line_store: the two line stores as one memory of {upper, middle} byte
// pairs, with a zero sweep after reset. Depends on gc3_pkg.
`timescale 1ns / 1ps

module gc3_line_store #(
    parameter int MAX_WIDTH = gc3_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     i_rd_addr,
    output logic [2*gc3_pkg::PIX_W-1:0]      o_rd_data,
    input  logic                             i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     i_wr_addr,
    input  logic [2*gc3_pkg::PIX_W-1:0]      i_wr_data,
    output logic                             o_busy
);
    import gc3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic [AW-1:0]      r_clr_addr;
    logic               r_busy;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [2*PIX_W-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        wr_en   = r_busy | i_wr_en;
        wr_addr = r_busy ? r_clr_addr : i_wr_addr;
        wr_data = r_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

// ===== rtl/gc3_ctrl.sv =====
// gc3_ctrl: raster counters, drain handling and result scheduling at the
// input side; loads the kernel stage register. Depends on gc3_pkg.
`timescale 1ns / 1ps

module gc3_ctrl #(
    parameter int MAX_WIDTH  = gc3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gc3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_op,
    input  logic [gc3_pkg::PIX_W-1:0]     i_pixel,
    input  logic [gc3_pkg::DIM_W-1:0]     i_cfg_width,
    input  logic [gc3_pkg::DIM_W-1:0]     i_cfg_height,
    output logic                          o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_rd_addr,
    output gc3_pkg::t_s1_ctl              o_s1,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_s1_addr,
    output logic [gc3_pkg::PIX_W-1:0]     o_s1_pix
);
    import gc3_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 3);
    localparam int DW  = $clog2(MAX_WIDTH + 2);

    logic [AW-1:0]  r_in_col,  n_in_col;
    logic [RW-1:0]  r_in_row,  n_in_row;
    logic [AW-1:0]  r_out_col, n_out_col;
    logic [HDW-1:0] r_out_row, n_out_row;
    // pushes not yet matched by a result
    logic [DW-1:0]  r_d,       n_d;
    t_s1_ctl        r_s1,      n_s1;
    logic [AW-1:0]  r_s1_addr;
    logic [PIX_W-1:0] r_s1_pix;

    logic [WDW-1:0] w;
    logic [HDW-1:0] h;
    logic           done;
    logic           push;
    logic [AW:0]    in_col_inc;
    logic           in_wrap;
    logic [AW:0]    out_col_inc;
    logic [HDW:0]   out_row_inc;
    logic           res;
    logic           left;
    logic           right;
    logic           top;
    logic           bottom;
    logic           last;

    always_comb begin
        if (i_cfg_width == '0) begin
            w = WDW'(1);
        end else if (32'(i_cfg_width) > 32'(MAX_WIDTH)) begin
            w = WDW'(MAX_WIDTH);
        end else begin
            w = WDW'(i_cfg_width);
        end
        if (i_cfg_height == '0) begin
            h = HDW'(1);
        end else if (32'(i_cfg_height) > 32'(MAX_HEIGHT)) begin
            h = HDW'(MAX_HEIGHT);
        end else begin
            h = HDW'(i_cfg_height);
        end

        done = r_in_row >= RW'(h);
        // a drain before the frame is fully in does nothing
        push = i_fire && !(i_op == OP_DRAIN && !done);

        in_col_inc  = {1'b0, r_in_col} + 1'b1;
        in_wrap     = in_col_inc >= (AW + 1)'(w);
        out_col_inc = {1'b0, r_out_col} + 1'b1;
        out_row_inc = {1'b0, r_out_row} + 1'b1;

        // enough pushes ahead for the next output's lower-right neighbor
        res    = r_d > DW'(w);
        left   = r_out_col == '0;
        right  = out_col_inc >= (AW + 1)'(w);
        top    = r_out_row == '0;
        bottom = out_row_inc >= (HDW + 1)'(h);
        last   = right && bottom;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_d       = r_d;
        if (push) begin
            if (res && last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_d       = '0;
            end else begin
                if (in_wrap) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = in_col_inc[AW-1:0];
                end
                if (res) begin
                    if (right) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = out_col_inc[AW-1:0];
                    end
                end else begin
                    n_d = r_d + 1'b1;
                end
            end
        end

        n_s1.valid  = push;
        // previous word writes this address in the cycle of our read
        n_s1.byp    = r_s1.valid && (r_s1_addr == r_in_col);
        n_s1.res    = res;
        n_s1.left   = left;
        n_s1.right  = right;
        n_s1.top    = top;
        n_s1.bottom = bottom;
        n_s1.last   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_d       <= '0;
            r_s1      <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_d       <= n_d;
            r_s1      <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_s1_addr <= r_in_col;
            r_s1_pix  <= done ? '0 : i_pixel;
        end
    end

    assign o_rd_en   = push;
    assign o_rd_addr = r_in_col;
    assign o_s1      = r_s1;
    assign o_s1_addr = r_s1_addr;
    assign o_s1_pix  = r_s1_pix;

endmodule

// ===== rtl/gc3_kernel.sv =====
// gc3_kernel: line store write-back, 3x3 window shift, edge masking and the
// weighted difference modulo 256. Depends on gc3_pkg.
`timescale 1ns / 1ps

module gc3_kernel #(
    parameter int MAX_WIDTH = gc3_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gc3_pkg::t_s1_ctl                    i_s1,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_s1_addr,
    input  logic [gc3_pkg::PIX_W-1:0]           i_s1_pix,
    input  logic [2*gc3_pkg::PIX_W-1:0]         i_rd_data,
    input  logic                                i_mode,
    input  logic signed [gc3_pkg::WEIGHT_W-1:0] i_weight_a,
    input  logic signed [gc3_pkg::WEIGHT_W-1:0] i_weight_c,
    input  logic signed [gc3_pkg::WEIGHT_W-1:0] i_weight_b,
    output logic                                o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_wr_addr,
    output logic [2*gc3_pkg::PIX_W-1:0]         o_wr_data,
    output logic                                o_push,
    output gc3_pkg::t_result                    o_result
);
    import gc3_pkg::*;

    t_wcol              r_win [3];
    logic [2*PIX_W-1:0] r_last_wr;

    logic [2*PIX_W-1:0] pair;
    t_wcol              col_new;
    t_wcol              p0;
    t_wcol              p1;
    t_wcol              p2;
    logic [PIX_W-1:0]   d_a;
    logic [PIX_W-1:0]   d_c;
    logic [PIX_W-1:0]   d_b;
    logic [PIX_W-1:0]   sum;

    always_comb begin
        pair         = i_s1.byp ? r_last_wr : i_rd_data;
        col_new.prev = pair[2*PIX_W-1:PIX_W];
        col_new.cur  = pair[PIX_W-1:0];
        col_new.next = i_s1_pix;

        p0 = r_win[1];
        p1 = r_win[2];
        p2 = col_new;
        // zero padding outside the image
        if (i_s1.left) begin
            p0 = '0;
        end
        if (i_s1.right) begin
            p2 = '0;
        end
        if (i_s1.top) begin
            p0.prev = '0;
            p1.prev = '0;
            p2.prev = '0;
        end
        if (i_s1.bottom) begin
            p0.next = '0;
            p1.next = '0;
            p2.next = '0;
        end

        if (i_mode == MODE_X) begin
            d_a = p0.next - p2.next;
            d_c = p0.cur  - p2.cur;
            d_b = p0.prev - p2.prev;
        end else begin
            d_a = p0.next - p0.prev;
            d_c = p1.next - p1.prev;
            d_b = p2.next - p2.prev;
        end
        sum = mul_lo8(i_weight_a, d_a) + mul_lo8(i_weight_c, d_c) + mul_lo8(i_weight_b, d_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_s1.valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= col_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1.valid) begin
            r_last_wr <= {col_new.cur, col_new.next};
        end
    end

    assign o_wr_en            = i_s1.valid;
    assign o_wr_addr          = i_s1_addr;
    assign o_wr_data          = {col_new.cur, col_new.next};
    assign o_push             = i_s1.valid && i_s1.res;
    assign o_result.gradient  = sum;
    assign o_result.frame_end = i_s1.last;

endmodule

// ===== rtl/gc3_out_fifo.sv =====
// gc3_out_fifo: small result queue that decouples the output handshake from
// the input side. Depends on gc3_pkg.
`timescale 1ns / 1ps

module gc3_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  gc3_pkg::t_result                 i_data,
    output logic                             o_valid,
    output gc3_pkg::t_result                 o_data,
    input  logic                             i_pop,
    output logic [gc3_pkg::FIFO_CNT_W-1:0]   o_count
);
    import gc3_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_count;

    logic                  pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

// ===== rtl/gradient_conv3x3_zero_pad_top.sv =====
// gradient_conv3x3_zero_pad_top: streaming 3x3 directional gradient, zero padded.
// Throughput one word per cycle while input ready is high; a window completes
// width+1 words after its pixel, and its result passes the kernel stage and queue.
// Line store is one read and one write per cycle; same-address reuse is bypassed.
// Reset: synchronous, clears control and config to defaults, then zero-sweeps
// every line store address with input ready held low.
`timescale 1ns / 1ps

module gradient_conv3x3_zero_pad_top #(
    parameter int MAX_WIDTH  = gc3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gc3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [gc3_pkg::PIX_W-1:0]          i_pixel,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gc3_pkg::PIX_W-1:0]          o_gradient,
    output logic                               o_frame_end,
    input  logic                               i_cfg_wr_en,
    input  logic [gc3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gc3_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import gc3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic                       r_mode;
    logic signed [WEIGHT_W-1:0] r_weight_a;
    logic signed [WEIGHT_W-1:0] r_weight_c;
    logic signed [WEIGHT_W-1:0] r_weight_b;
    logic [DIM_W-1:0]           r_width;
    logic [DIM_W-1:0]           r_height;

    logic                  fire;
    logic                  busy;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [2*PIX_W-1:0]    rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [2*PIX_W-1:0]    wr_data;
    t_s1_ctl               s1;
    logic [AW-1:0]         s1_addr;
    logic [PIX_W-1:0]      s1_pix;
    logic                  res_push;
    t_result               res_data;
    t_result               out_data;
    logic [FIFO_CNT_W-1:0] fifo_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= RST_MODE;
            r_weight_a <= RST_WEIGHT_A;
            r_weight_c <= RST_WEIGHT_C;
            r_weight_b <= RST_WEIGHT_B;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MODE:     r_mode     <= i_cfg_wdata[0];
                CFG_WEIGHT_A: r_weight_a <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_WEIGHT_C: r_weight_c <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_WEIGHT_B: r_weight_b <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_WIDTH:    r_width    <= i_cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // room for the word in the kernel stage plus the new one
    assign o_in_ready = !busy &&
        ((3'(fifo_count) + 3'(s1.valid)) <= 3'(FIFO_DEPTH - 1));
    assign fire = i_in_valid && o_in_ready;

    gc3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_op         (i_op),
        .i_pixel      (i_pixel),
        .i_cfg_width  (r_width),
        .i_cfg_height (r_height),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_s1         (s1),
        .o_s1_addr    (s1_addr),
        .o_s1_pix     (s1_pix)
    );

    gc3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_busy    (busy)
    );

    gc3_kernel #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_kernel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1       (s1),
        .i_s1_addr  (s1_addr),
        .i_s1_pix   (s1_pix),
        .i_rd_data  (rd_data),
        .i_mode     (r_mode),
        .i_weight_a (r_weight_a),
        .i_weight_c (r_weight_c),
        .i_weight_b (r_weight_b),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (res_push),
        .o_result   (res_data)
    );

    gc3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_pop   (i_out_ready),
        .o_count (fifo_count)
    );

    assign o_gradient  = out_data.gradient;
    assign o_frame_end = out_data.frame_end;

    // nothing is in flight while the line stores are being cleared
    a_idle_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (!s1.valid && fifo_count == '0))
        else $error("word in flight during line store clear");

    // queue plus kernel stage never exceed the queue depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (3'(fifo_count) + 3'(s1.valid)) <= 3'(FIFO_DEPTH))
        else $error("result queue overrun");

    // bypass only follows a word that wrote the store in the cycle before
    a_bypass_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1.valid && s1.byp) |-> $past(s1.valid))
        else $error("line store bypass without a preceding write");

endmodule
